### hdl/dfpar_pkg.sv
package dfpar_pkg;

    localparam int FRAME_LEN_DEF  = 32;
    localparam int WINDOW_LEN_DEF = 28;
    localparam int QUEUE_DEPTH    = 2;

    localparam logic [7:0] HDR0 = 8'h42;
    localparam logic [7:0] HDR1 = 8'h4D;

    localparam int PM_HI_POS   = 12;
    localparam int PM_LO_POS   = 13;
    localparam int DUST_HI_POS = 18;
    localparam int DUST_LO_POS = 19;

    localparam logic [1:0] ST_GOOD    = 2'd0;
    localparam logic [1:0] ST_BAD_HDR = 2'd1;
    localparam logic [1:0] ST_BAD_SUM = 2'd2;

    localparam logic [8:0] COUNT_MAX = 9'd511;
    localparam int         NUM_MARKS = 6;
    localparam logic [8:0] MARKS [NUM_MARKS] = '{9'd100, 9'd145, 9'd200, 9'd220, 9'd240, 9'd280};

    localparam logic [15:0] BAND0_MAX = 16'd2;
    localparam logic [15:0] BAND1_MAX = 16'd10;
    localparam logic [15:0] BAND2_MAX = 16'd30;
    localparam logic [15:0] BAND3_MAX = 16'd100;
    localparam logic [15:0] BAND4_MAX = 16'd200;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] pm;
        logic [15:0] dust;
    } frame_desc_t;

    function automatic logic [8:0] band_mark(input logic [15:0] g);
        logic [8:0] m;
        priority if (g <= BAND0_MAX) m = MARKS[0];
        else if (g <= BAND1_MAX)     m = MARKS[1];
        else if (g <= BAND2_MAX)     m = MARKS[2];
        else if (g <= BAND3_MAX)     m = MARKS[3];
        else if (g <= BAND4_MAX)     m = MARKS[4];
        else                         m = MARKS[5];
        return m;
    endfunction

endpackage

### hdl/dust_frame_parser_adaptive_report.sv
// Takes one byte per cycle while in_ready is high; the last byte of a frame
// queues one frame item. The result register loads once the output is free,
// after the multiply and fix states when the frame fills the window
// (reciprocal multiply and correction for the mean difference).
// Reset (rst_n, async, active low) clears byte position, queue, counters,
// window fill, gap and output valid; no clearing pass.
module dust_frame_parser_adaptive_report #(
    parameter int FRAME_LEN  = dfpar_pkg::FRAME_LEN_DEF,
    parameter int WINDOW_LEN = dfpar_pkg::WINDOW_LEN_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  rx_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  frame_status,
    output logic [15:0] pm25_value,
    output logic [15:0] dust_value,
    output logic [15:0] gap_value,
    output logic        report_valid,
    output logic [19:0] report_value,
    output logic        reset_request
);

    dfpar_pkg::frame_desc_t push_data, head;
    logic q_push, q_full, q_pop, q_empty;

    dfpar_front #(
        .FRAME_LEN(FRAME_LEN)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .rx_byte  (rx_byte),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_data   (push_data)
    );

    dfpar_queue #(
        .DEPTH(dfpar_pkg::QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (push_data),
        .full      (q_full),
        .pop       (q_pop),
        .empty     (q_empty),
        .head      (head)
    );

    dfpar_back #(
        .WINDOW_LEN(WINDOW_LEN)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_empty       (q_empty),
        .q_head        (head),
        .q_pop         (q_pop),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .frame_status  (frame_status),
        .pm25_value    (pm25_value),
        .dust_value    (dust_value),
        .gap_value     (gap_value),
        .report_valid  (report_valid),
        .report_value  (report_value),
        .reset_request (reset_request)
    );

endmodule

### hdl/dfpar_front.sv
module dfpar_front #(
    parameter int FRAME_LEN = dfpar_pkg::FRAME_LEN_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [7:0]             rx_byte,
    input  logic                   q_full,
    output logic                   q_push,
    output dfpar_pkg::frame_desc_t q_data
);

    localparam int IDX_W = $clog2(FRAME_LEN);
    localparam int SUM_W = 8 + $clog2(FRAME_LEN);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(FRAME_LEN - 1);
    localparam logic [IDX_W-1:0] HI_IDX   = IDX_W'(FRAME_LEN - 2);
    localparam logic [IDX_W-1:0] SUM_END  = IDX_W'(FRAME_LEN - 3);

    logic [IDX_W-1:0] idx_reg, idx_next;
    logic             hdr_ok_reg, hdr_ok_next;
    logic [SUM_W-1:0] sum_reg, sum_next;
    logic [7:0]       word_hi_reg, word_hi_next;
    logic [15:0]      pm_reg, pm_next;
    logic [15:0]      dust_reg, dust_next;
    logic             is_last, accept;

    assign is_last  = (idx_reg == LAST_IDX);
    assign in_ready = !is_last || !q_full;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        idx_next     = idx_reg;
        hdr_ok_next  = hdr_ok_reg;
        sum_next     = sum_reg;
        word_hi_next = word_hi_reg;
        pm_next      = pm_reg;
        dust_next    = dust_reg;
        if (accept)
        begin
            idx_next = is_last ? '0 : idx_reg + 1'b1;
            if (idx_reg == '0)
            begin
                hdr_ok_next = (rx_byte == dfpar_pkg::HDR0);
                sum_next    = SUM_W'(rx_byte);
                pm_next     = '0;
                dust_next   = '0;
            end
            else
            begin
                if (idx_reg == IDX_W'(1))
                    hdr_ok_next = hdr_ok_reg && (rx_byte == dfpar_pkg::HDR1);
                if (idx_reg <= SUM_END)
                    sum_next = sum_reg + SUM_W'(rx_byte);
            end
            if (idx_reg == HI_IDX)
                word_hi_next = rx_byte;
            if (32'(idx_reg) == dfpar_pkg::PM_HI_POS)
                pm_next[15:8] = rx_byte;
            if (32'(idx_reg) == dfpar_pkg::PM_LO_POS)
                pm_next[7:0] = rx_byte;
            if (32'(idx_reg) == dfpar_pkg::DUST_HI_POS)
                dust_next[15:8] = rx_byte;
            if (32'(idx_reg) == dfpar_pkg::DUST_LO_POS)
                dust_next[7:0] = rx_byte;
        end
    end

    assign q_push = accept && is_last;

    always_comb
    begin
        q_data.pm   = pm_next;
        q_data.dust = dust_next;
        if (!hdr_ok_reg)
            q_data.status = dfpar_pkg::ST_BAD_HDR;
        else if (16'(sum_reg) != {word_hi_reg, rx_byte})
            q_data.status = dfpar_pkg::ST_BAD_SUM;
        else
            q_data.status = dfpar_pkg::ST_GOOD;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            idx_reg <= '0;
        else
            idx_reg <= idx_next;
    end

    always_ff @(posedge clk)
    begin
        hdr_ok_reg  <= hdr_ok_next;
        sum_reg     <= sum_next;
        word_hi_reg <= word_hi_next;
        pm_reg      <= pm_next;
        dust_reg    <= dust_next;
    end

endmodule

### hdl/dfpar_queue.sv
module dfpar_queue #(
    parameter int DEPTH = dfpar_pkg::QUEUE_DEPTH
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  dfpar_pkg::frame_desc_t push_data,
    output logic                   full,
    input  logic                   pop,
    output logic                   empty,
    output dfpar_pkg::frame_desc_t head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

    dfpar_pkg::frame_desc_t slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign head    = slot_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= push_data;
    end

endmodule

### hdl/dfpar_back.sv
module dfpar_back #(
    parameter int WINDOW_LEN = dfpar_pkg::WINDOW_LEN_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   q_empty,
    input  dfpar_pkg::frame_desc_t q_head,
    output logic                   q_pop,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [1:0]             frame_status,
    output logic [15:0]            pm25_value,
    output logic [15:0]            dust_value,
    output logic [15:0]            gap_value,
    output logic                   report_valid,
    output logic [19:0]            report_value,
    output logic                   reset_request
);

    localparam int FILL_W = $clog2(WINDOW_LEN + 1);
    localparam int ACC_W  = 16 + $clog2(WINDOW_LEN);
    localparam int DIVISOR = WINDOW_LEN - 1;
    localparam logic [ACC_W:0] RECIP = (ACC_W+1)'((64'd1 << ACC_W) / DIVISOR);
    localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(WINDOW_LEN);
    localparam logic [ACC_W-1:0]  DIV_C = ACC_W'(DIVISOR);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_MUL  = 2'd1;
    localparam logic [1:0] S_FIX  = 2'd2;

    logic [1:0]        state_reg, state_next;
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic              gap_done_reg, gap_done_next;
    logic [15:0]       gap_reg, gap_next;
    logic [8:0]        good_reg, good_next;
    logic [8:0]        mark_reg, mark_next;
    logic [15:0]       prev_reg, prev_next;
    logic [ACC_W-1:0]  acc_reg, acc_next;
    logic [2*ACC_W:0]  prod_reg, prod_next;
    logic [15:0]       pend_pm_reg, pend_pm_next;
    logic [15:0]       pend_dust_reg, pend_dust_next;

    logic              out_valid_reg, out_valid_next;
    logic              load_out;
    logic [1:0]        o_status;
    logic [15:0]       o_pm, o_dust, o_gap;
    logic              o_report;
    logic [1:0]        status_reg;
    logic [15:0]       pm_reg, dust_reg, gapo_reg;
    logic              report_reg;

    logic              out_free;
    logic [15:0]       diff;
    logic [FILL_W-1:0] fill_w;
    logic [ACC_W-1:0]  acc_w;
    logic [8:0]        mark_w, good_w;
    logic              report_w;
    logic [ACC_W-1:0]  q0, rem;
    logic [15:0]       gap_calc;

    assign out_free = !out_valid_reg || out_ready;

    assign diff = (q_head.dust > prev_reg) ? q_head.dust - prev_reg : prev_reg - q_head.dust;

    always_comb
    begin
        fill_w = fill_reg;
        acc_w  = acc_reg;
        if (fill_reg < FILL_FULL)
        begin
            fill_w = fill_reg + 1'b1;
            acc_w  = (fill_reg == '0) ? '0 : acc_reg + ACC_W'(diff);
        end
        mark_w = mark_reg;
        for (int i = 0; i < dfpar_pkg::NUM_MARKS; i++)
            if (good_reg == dfpar_pkg::MARKS[i])
                mark_w = dfpar_pkg::MARKS[i];
        good_w = (good_reg < dfpar_pkg::COUNT_MAX) ? good_reg + 1'b1 : good_reg;
        report_w = (mark_w == dfpar_pkg::band_mark(gap_reg));
    end

    // reciprocal estimate is exact or one low
    always_comb
    begin
        q0  = prod_reg[2*ACC_W-1:ACC_W];
        rem = acc_reg - ACC_W'(q0 * DIV_C);
        gap_calc = (rem >= DIV_C) ? 16'(q0 + 1'b1) : 16'(q0);
    end

    always_comb
    begin
        state_next     = state_reg;
        fill_next      = fill_reg;
        gap_done_next  = gap_done_reg;
        gap_next       = gap_reg;
        good_next      = good_reg;
        mark_next      = mark_reg;
        prev_next      = prev_reg;
        acc_next       = acc_reg;
        prod_next      = prod_reg;
        pend_pm_next   = pend_pm_reg;
        pend_dust_next = pend_dust_reg;
        q_pop          = 1'b0;
        load_out       = 1'b0;
        o_status       = dfpar_pkg::ST_GOOD;
        o_pm           = '0;
        o_dust         = '0;
        o_gap          = gap_reg;
        o_report       = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (!q_empty && out_free)
                begin
                    q_pop = 1'b1;
                    if (q_head.status != dfpar_pkg::ST_GOOD)
                    begin
                        load_out = 1'b1;
                        o_status = q_head.status;
                    end
                    else
                    begin
                        if (fill_reg < FILL_FULL)
                            prev_next = q_head.dust;
                        fill_next = fill_w;
                        acc_next  = acc_w;
                        mark_next = mark_w;
                        good_next = good_w;
                        if (fill_w == FILL_FULL && !gap_done_reg)
                        begin
                            gap_done_next  = 1'b1;
                            pend_pm_next   = q_head.pm;
                            pend_dust_next = q_head.dust;
                            state_next     = S_MUL;
                        end
                        else
                        begin
                            load_out = 1'b1;
                            o_pm     = q_head.pm;
                            o_dust   = q_head.dust;
                            o_report = report_w;
                            if (report_w)
                            begin
                                fill_next     = '0;
                                good_next     = '0;
                                mark_next     = '0;
                                gap_done_next = 1'b0;
                            end
                        end
                    end
                end
            end
            S_MUL:
            begin
                prod_next  = (2*ACC_W+1)'(acc_reg * RECIP);
                state_next = S_FIX;
            end
            S_FIX:
            begin
                if (out_free)
                begin
                    gap_next = gap_calc;
                    load_out = 1'b1;
                    o_pm     = pend_pm_reg;
                    o_dust   = pend_dust_reg;
                    o_gap    = gap_calc;
                    o_report = (mark_reg == dfpar_pkg::band_mark(gap_calc));
                    if (o_report)
                    begin
                        fill_next     = '0;
                        good_next     = '0;
                        mark_next     = '0;
                        gap_done_next = 1'b0;
                    end
                    state_next = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_out)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            fill_reg      <= '0;
            gap_done_reg  <= 1'b0;
            gap_reg       <= '0;
            good_reg      <= '0;
            mark_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            gap_done_reg  <= gap_done_next;
            gap_reg       <= gap_next;
            good_reg      <= good_next;
            mark_reg      <= mark_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prev_reg      <= prev_next;
        acc_reg       <= acc_next;
        prod_reg      <= prod_next;
        pend_pm_reg   <= pend_pm_next;
        pend_dust_reg <= pend_dust_next;
        if (load_out)
        begin
            status_reg <= o_status;
            pm_reg     <= o_pm;
            dust_reg   <= o_dust;
            gapo_reg   <= o_gap;
            report_reg <= o_report;
        end
    end

    assign out_valid     = out_valid_reg;
    assign frame_status  = status_reg;
    assign pm25_value    = pm_reg;
    assign dust_value    = dust_reg;
    assign gap_value     = gapo_reg;
    assign report_valid  = report_reg;
    assign reset_request = report_reg;
    assign report_value  = report_reg ? (20'(dust_reg) << 3) + (20'(dust_reg) << 1) : '0;

endmodule
